// ===== hdl/mca_pkg.sv =====
`timescale 1ns / 1ps
package mca_pkg;
    localparam int Inputs      = 784;
    localparam int HiddenUnits = 128;
    localparam int Classes     = 10;
    localparam int HidW  = $clog2(HiddenUnits);
    localparam int PixW  = $clog2(Inputs);
    localparam int ClsW  = 4;
    localparam int W1Depth = HiddenUnits * Inputs;
    localparam int W1W   = $clog2(W1Depth);
    localparam int W2Depth = Classes * HiddenUnits;
    localparam int W2W   = $clog2(W2Depth);
    localparam int TallyW = 20;
    localparam logic [TallyW-1:0] TallyMax = '1;

    typedef enum logic [2:0] {
        ACT_W1    = 3'd0,
        ACT_HBIAS = 3'd1,
        ACT_W2    = 3'd2,
        ACT_OBIAS = 3'd3,
        ACT_PIXEL = 3'd4,
        ACT_CLEAR = 3'd5
    } t_action;

    typedef struct packed {
        logic [2:0]  action;
        logic [16:0] index;
        logic signed [15:0] value;
        logic [3:0]  label;
        logic        last;
    } t_in;

    typedef struct packed {
        logic [3:0]        predicted;
        logic              correct;
        logic [TallyW-1:0] correct_count;
        logic [TallyW-1:0] images_seen;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic           load;      // capture input item
        logic           acc;       // accumulate hidden unit at cnt_j
        logic           act;       // form activation at cnt_j and clear sum
        logic           mac;       // output mac for class cnt_k, unit cnt_j
        logic           cls_start; // start output sum with bias
        logic           cls_end;   // compare finished output sum
        logic           finish;    // update tallies and result
        logic           emit;      // copy result into the output register
        logic           clear;     // clear tallies
        logic [HidW-1:0] cnt_j;
        logic [ClsW-1:0] cnt_k;
    } t_cmd;
endpackage

// ===== hdl/mca_if.sv =====
`timescale 1ns / 1ps
interface mca_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/mca_datapath.sv =====
`timescale 1ns / 1ps
module mca_datapath import mca_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_item,
    input  t_cmd i_cmd,
    output t_in  o_item,
    output t_out o_result
);
    logic signed [15:0] r_w1 [W1Depth];
    logic signed [15:0] r_hb [HiddenUnits];
    logic signed [15:0] r_w2 [W2Depth];
    logic signed [15:0] r_ob [Classes];
    logic signed [47:0] r_hs [HiddenUnits];
    logic [HiddenUnits-1:0] r_hs_vld;
    logic signed [15:0] r_hid [HiddenUnits];
    t_in r_item;
    logic signed [15:0] r_w1_q, r_w2_q, r_hb_q, r_hid_q;
    logic signed [47:0] r_hs_q, r_hs_qq;
    logic r_hs_ok;
    logic signed [47:0] hs_rd;
    logic signed [31:0] r_prod;
    logic signed [63:0] r_osum, r_best;
    logic [3:0] r_pred;
    logic [TallyW-1:0] r_right, r_seen;
    logic r_ok;
    t_out r_res;
    logic [W1W-1:0] w1_addr;
    logic [W2W-1:0] w2_addr;
    logic signed [48:0] sum_ext;
    logic signed [47:0] sum_sat;
    logic signed [48:0] z;
    logic signed [48:0] zr;
    logic signed [15:0] h;
    logic [HidW-1:0] r_j_d, r_j_dd;
    logic r_acc_d, r_acc_dd, r_act_d;
    logic signed [31:0] r_mprod;
    logic r_mac_d, r_mac_dd;

    assign o_item = r_item;
    assign w1_addr = W1W'(i_cmd.cnt_j * Inputs + r_item.index[PixW-1:0]);
    assign w2_addr = W2W'(i_cmd.cnt_k * HiddenUnits + i_cmd.cnt_j);

    // capture item and write stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
            unique case (i_item.action)
                ACT_W1: if (i_item.index < W1Depth) r_w1[i_item.index[W1W-1:0]] <= i_item.value;
                ACT_HBIAS: begin
                    if (i_item.index < HiddenUnits) r_hb[i_item.index[HidW-1:0]] <= i_item.value;
                end
                ACT_W2: if (i_item.index < W2Depth) r_w2[i_item.index[W2W-1:0]] <= i_item.value;
                ACT_OBIAS: if (i_item.index < Classes) r_ob[i_item.index[3:0]] <= i_item.value;
                default: ;
            endcase
        end
    end

    // registered memory reads
    always_ff @(posedge i_clk) begin
        r_w1_q  <= r_w1[w1_addr];
        r_w2_q  <= r_w2[w2_addr];
        r_hb_q  <= r_hb[i_cmd.cnt_j];
        r_hs_q  <= r_hs[i_cmd.cnt_j];
        r_hs_ok <= r_hs_vld[i_cmd.cnt_j];
        r_hid_q <= r_hid[i_cmd.cnt_j];
    end

    // a hidden sum not yet written since reset reads as zero
    assign hs_rd = r_hs_ok ? r_hs_q : '0;

    // hidden sum update, saturating, and rounded ReLU activation
    always_comb begin
        sum_ext = 49'(r_hs_qq) + 49'(r_prod);
        if (sum_ext > 49'sh7FFF_FFFF_FFFF) sum_sat = 48'sh7FFF_FFFF_FFFF;
        else if (sum_ext < -49'sh8000_0000_0000) sum_sat = 48'sh8000_0000_0000;
        else sum_sat = sum_ext[47:0];
        z  = 49'(hs_rd) + 49'(r_hb_q) * 49'sd4096;
        zr = (z + 49'sd2048) >>> 12;
        if (z <= 0) h = '0;
        else if (zr > 49'sd32767) h = 16'sd32767;
        else h = zr[15:0];
    end

    // pipelined hidden pass: read, multiply, write back
    always_ff @(posedge i_clk) begin
        r_j_d    <= i_cmd.cnt_j;
        r_j_dd   <= r_j_d;
        r_acc_d  <= i_cmd.acc;
        r_acc_dd <= r_acc_d;
        r_act_d  <= i_cmd.act;
        r_hs_qq  <= hs_rd;
        r_prod   <= r_w1_q * r_item.value;
    end
    always_ff @(posedge i_clk) begin
        if (r_acc_dd) begin
            r_hs[r_j_dd] <= sum_sat;
        end else if (r_act_d) begin
            r_hid[r_j_d] <= h;
            r_hs[r_j_d]  <= '0;
        end
    end

    // mark hidden sums written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hs_vld <= '0;
        end else if (r_acc_dd) begin
            r_hs_vld[r_j_dd] <= 1'b1;
        end else if (r_act_d) begin
            r_hs_vld[r_j_d] <= 1'b1;
        end
    end

    // output sums and first-maximum search
    always_ff @(posedge i_clk) begin
        r_mac_d  <= i_cmd.mac;
        r_mac_dd <= r_mac_d;
        r_mprod  <= r_w2_q * r_hid_q;
        if (i_cmd.cls_start) r_osum <= 64'(r_ob[i_cmd.cnt_k]) * 64'sd4096;
        else if (r_mac_dd) r_osum <= r_osum + 64'(r_mprod);
        if (i_cmd.cls_end && (i_cmd.cnt_k == '0 || r_osum > r_best)) begin
            r_best <= r_osum;
            r_pred <= i_cmd.cnt_k;
        end
    end

    // tallies
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right <= '0;
            r_seen  <= '0;
            r_ok    <= 1'b0;
        end else if (i_cmd.clear) begin
            r_right <= '0;
            r_seen  <= '0;
        end else if (i_cmd.finish) begin
            r_ok <= (r_pred == r_item.label);
            if (r_seen != TallyMax) r_seen <= r_seen + 1'b1;
            if (r_pred == r_item.label && r_right != TallyMax) r_right <= r_right + 1'b1;
        end
    end

    // hold the result in the output register until the next one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else if (i_cmd.emit) begin
            r_res <= '{predicted: r_pred, correct: r_ok,
                       correct_count: r_right, images_seen: r_seen};
        end
    end
    assign o_result = r_res;
endmodule

// ===== hdl/mca_ctrl.sv =====
`timescale 1ns / 1ps
module mca_ctrl import mca_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_item,
    input  t_in  i_cur,
    output t_cmd o_cmd,
    output logic o_out_valid,
    input  logic i_out_ready
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_DECODE = 7'b0000010, S_ACC = 7'b0000100,
        S_ACT = 7'b0001000, S_CLS = 7'b0010000, S_DONE = 7'b0100000,
        S_OUT = 7'b1000000
    } t_state;
    t_state r_state, n_state;
    logic [HidW+2:0] r_cnt, n_cnt;
    logic [ClsW-1:0] r_k, n_k;
    logic r_valid, n_valid;

    localparam int HidLast = HiddenUnits - 1;
    localparam int Drain = 3;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_valid;

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_k = r_k; n_valid = r_valid;
        o_cmd = '0;
        o_cmd.cnt_j = r_cnt[HidW-1:0];
        o_cmd.cnt_k = r_k;
        if (r_valid && i_out_ready) n_valid = 1'b0;
        unique case (r_state)
            S_IDLE: if (i_in_valid) begin
                o_cmd.load = 1'b1;
                o_cmd.clear = (i_item.action == ACT_CLEAR);
                n_state = (i_item.action == ACT_PIXEL) ? S_DECODE : S_IDLE;
                n_cnt = '0;
            end
            S_DECODE: begin
                n_cnt = '0;
                if (i_cur.index < Inputs) n_state = S_ACC;
                else n_state = i_cur.last ? S_ACT : S_IDLE;
            end
            S_ACC: begin
                // walk hidden units, then drain the write pipeline
                o_cmd.acc = (r_cnt <= HidLast);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (HidLast + Drain)) begin
                    n_cnt = '0;
                    n_state = i_cur.last ? S_ACT : S_IDLE;
                end
            end
            S_ACT: begin
                o_cmd.act = (r_cnt <= HidLast);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (HidLast + Drain)) begin
                    n_cnt = '0; n_k = '0; n_state = S_CLS;
                end
            end
            S_CLS: begin
                o_cmd.cls_start = (r_cnt == '0);
                o_cmd.mac = (r_cnt <= HidLast);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (HidLast + Drain + 1)) begin
                    o_cmd.cls_end = 1'b1;
                    n_cnt = '0;
                    n_k = r_k + 1'b1;
                    if (r_k == ClsW'(Classes - 1)) n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                // wait until the output register is free
                if (!r_valid || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cnt <= '0; r_k <= '0; r_valid <= 1'b0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_k <= n_k; r_valid <= n_valid;
        end
    end
endmodule

// ===== hdl/mlp_classifier_accuracy.sv =====
`timescale 1ns / 1ps
// Two-layer ReLU perceptron classifier with accuracy tally. A pixel is
// accumulated by a single shared multiplier that walks the hidden units (an
// out-of-range pixel skips that walk); the last pixel adds a pass for
// activations, the output sums through the same kind of shared multiplier,
// and the posting of the result. One result per image, held in an output
// register until taken; input is accepted only in the idle state, so it
// stalls while a pixel or image is processed, and when the next result is
// ready before the held one is taken.
module mlp_classifier_accuracy import mca_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    mca_if.sink   i_in,
    mca_if.source o_out
);
    t_cmd cmd;
    t_in  cur;
    t_out res;

    mca_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(i_in.valid), .o_in_ready(i_in.ready),
        .i_item(t_in'(i_in.data)), .i_cur(cur), .o_cmd(cmd),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready)
    );
    mca_datapath u_dp (
        .i_clk, .i_rst_n, .i_item(t_in'(i_in.data)), .i_cmd(cmd),
        .o_item(cur), .o_result(res)
    );
    assign o_out.data = res;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.acc |-> !i_in.ready) else $error("accept during accumulate");
    a_stable_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> $stable(o_out.data))
        else $error("result changed while held");
    a_tally_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.correct_count <= res.images_seen || cmd.clear)
        else $error("correct exceeds seen");
endmodule
